[design/gssg_pkg.sv]
// Shared types and constants for the spectral subtraction gain pipeline.
package gssg_pkg;

  localparam int unsigned IDX_W  = 13;
  localparam int unsigned GAIN_W = 16;
  localparam int unsigned FACT_W = 16;
  localparam int unsigned QUOT_W = 32;
  localparam int unsigned ROOT_STEPS = QUOT_W / 2;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'd4096;
  localparam logic [GAIN_W-1:0] SAT_GAIN   = 16'hFFFF;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] mirr_idx;
    logic             mirror;
    logic             unity;
    logic             sat;
  } meta_t;

endpackage

[design/gssg_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module gssg_div
  import gssg_pkg::*;
#(
  parameter int unsigned DW = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  meta_t                meta_i,
  input  logic [DW-1:0]        divisor_i,
  input  logic [DW+QUOT_W-1:0] dividend_i,
  output logic                 valid_o,
  output meta_t                meta_o,
  output logic [QUOT_W-1:0]    quot_o
);

  localparam int unsigned XW = DW + QUOT_W;

  logic              v_q [QUOT_W];
  meta_t             m_q [QUOT_W];
  logic [DW-1:0]     d_q [QUOT_W];
  logic [XW-1:0]     x_q [QUOT_W];
  logic [QUOT_W-1:0] r_q [QUOT_W];

  for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
    localparam int unsigned SH = QUOT_W - 1 - k;
    logic              v_p;
    meta_t             m_p;
    logic [DW-1:0]     d_p;
    logic [XW-1:0]     x_p;
    logic [QUOT_W-1:0] r_p;
    logic [XW-1:0]     trial;
    logic              take;

    if (k == 0) begin : g_first
      assign v_p = valid_i;
      assign m_p = meta_i;
      assign d_p = divisor_i;
      assign x_p = dividend_i;
      assign r_p = '0;
    end else begin : g_next
      assign v_p = v_q[k-1];
      assign m_p = m_q[k-1];
      assign d_p = d_q[k-1];
      assign x_p = x_q[k-1];
      assign r_p = r_q[k-1];
    end

    assign trial = XW'(d_p) << SH;
    assign take  = (x_p >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[k] <= m_p;
        d_q[k] <= d_p;
        x_q[k] <= take ? (x_p - trial) : x_p;
        r_q[k] <= r_p | (QUOT_W'(take) << SH);
      end
    end
  end

  assign valid_o = v_q[QUOT_W-1];
  assign meta_o  = m_q[QUOT_W-1];
  assign quot_o  = r_q[QUOT_W-1];

endmodule

[design/gssg_sqrt.sv]
// Pipelined integer square root, one root bit per stage.
module gssg_sqrt
  import gssg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  meta_t             meta_i,
  input  logic [QUOT_W-1:0] rad_i,
  output logic              valid_o,
  output meta_t             meta_o,
  output logic [GAIN_W-1:0] root_o
);

  logic              v_q [ROOT_STEPS];
  meta_t             m_q [ROOT_STEPS];
  logic [QUOT_W-1:0] q_q [ROOT_STEPS];
  logic [QUOT_W-1:0] r_q [ROOT_STEPS];

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_stage
    localparam int unsigned BP = QUOT_W - 2 - 2 * k;
    logic              v_p;
    meta_t             m_p;
    logic [QUOT_W-1:0] q_p;
    logic [QUOT_W-1:0] r_p;
    logic [QUOT_W:0]   trial;
    logic              take;

    if (k == 0) begin : g_first
      assign v_p = valid_i;
      assign m_p = meta_i;
      assign q_p = rad_i;
      assign r_p = '0;
    end else begin : g_next
      assign v_p = v_q[k-1];
      assign m_p = m_q[k-1];
      assign q_p = q_q[k-1];
      assign r_p = r_q[k-1];
    end

    assign trial = {1'b0, r_p} + ((QUOT_W + 1)'(1) << BP);
    assign take  = ({1'b0, q_p} >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[k] <= m_p;
        if (take) begin
          q_q[k] <= q_p - QUOT_W'(trial);
          r_q[k] <= (r_p >> 1) + (QUOT_W'(1) << BP);
        end else begin
          q_q[k] <= q_p;
          r_q[k] <= r_p >> 1;
        end
      end
    end
  end

  assign valid_o = v_q[ROOT_STEPS-1];
  assign meta_o  = m_q[ROOT_STEPS-1];
  assign root_o  = GAIN_W'(r_q[ROOT_STEPS-1]);

endmodule

[design/generalized_spectral_subtraction_gain.sv]
// Top level: power subtraction gain per bin with mirrored output index.
// Pipeline from input transfer to first result: 6 front stages, 32 divider
// stages, 16 root stages, 1 output register. Throughput: one bin per cycle
// without mirror while the output is not stalled; a mirrored bin holds the
// pipeline while the single output register emits both results of the bin.
// Reset clears all valid bits and sets half_size to 512; payload is not reset.
module generalized_spectral_subtraction_gain
  import gssg_pkg::*;
#(
  parameter int unsigned MAX_HALF_BINS = 4096,
  parameter int unsigned POWER_BITS    = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_wr_en_i,
  input  logic [IDX_W-1:0] cfg_wr_data_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // bin_index[12:0], signal_power[44:13], noise_power[76:45],
  // oversub_factor[92:77], floor_factor[108:93], zero fill
  input  logic [111:0]     s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // gain[15:0], gain_index[28:16], zero fill
  output logic [31:0]      m_axis_tdata,
  output logic             m_axis_tlast
);

  localparam int unsigned PB   = POWER_BITS;
  localparam int unsigned H    = (PB + 1) / 2;
  localparam int unsigned PW   = 2 * H;
  localparam int unsigned QW   = 4 * H;
  localparam int unsigned SQW  = 2 * PB;
  localparam int unsigned CPW  = H + FACT_W;
  localparam int unsigned NAW  = SQW + FACT_W;
  localparam int unsigned XW   = SQW + QUOT_W;
  localparam int unsigned HW   = 17;

  logic en;

  logic [IDX_W-1:0] half_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= 13'd512;
    end else if (cfg_wr_en_i) begin
      half_q <= cfg_wr_data_i;
    end
  end

  logic [IDX_W-1:0]  in_idx;
  logic [PB-1:0]     in_s, in_n;
  logic [FACT_W-1:0] in_a, in_b;
  logic [PW-1:0]     s_e, n_e;
  logic [H-1:0]      s_lo, s_hi, n_lo, n_hi;
  logic [IDX_W-1:0]  half_eff;
  meta_t             meta_in;

  assign in_idx = s_axis_tdata[12:0];
  assign in_s   = PB'(s_axis_tdata[44:13]);
  assign in_n   = PB'(s_axis_tdata[76:45]);
  assign in_a   = s_axis_tdata[92:77];
  assign in_b   = s_axis_tdata[108:93];
  assign s_e    = PW'(in_s);
  assign n_e    = PW'(in_n);
  assign s_lo   = s_e[H-1:0];
  assign s_hi   = s_e[PW-1:H];
  assign n_lo   = n_e[H-1:0];
  assign n_hi   = n_e[PW-1:H];

  assign half_eff = ({4'b0, half_q} > HW'(MAX_HALF_BINS)) ? IDX_W'(MAX_HALF_BINS) : half_q;

  always_comb begin
    meta_in.idx      = in_idx;
    meta_in.mirr_idx = IDX_W'({1'b0, half_eff, 1'b0} - {2'b0, in_idx});
    meta_in.mirror   = (in_idx != '0) && (in_idx < half_eff);
    meta_in.unity    = (in_s == '0);
    meta_in.sat      = 1'b0;
  end

  // Stage 1: half-width partial products of the squares
  logic              v1_q;
  meta_t             m1_q;
  logic [PW-1:0]     sll_q, slh_q, shh_q, nll_q, nlh_q, nhh_q;
  logic [FACT_W-1:0] a1_q, b1_q;

  // Stage 2: squares
  logic              v2_q;
  meta_t             m2_q;
  logic [SQW-1:0]    s2_2_q, n2_2_q;
  logic [FACT_W-1:0] a2_q, b2_q;

  // Stage 3: chunk products of the noise square with the factors
  logic           v3_q;
  meta_t          m3_q;
  logic [SQW-1:0] s2_3_q;
  logic [CPW-1:0] pa_q [4];
  logic [CPW-1:0] pb_q [4];
  logic [QW-1:0]  n2_ext;

  // Stage 4: weighted noise squares
  logic           v4_q;
  meta_t          m4_q;
  logic [SQW-1:0] s2_4_q;
  logic [NAW-1:0] na_4_q, nb_4_q;
  logic [QW+FACT_W-1:0] na_acc, nb_acc;

  // Stage 5: branch select
  logic           v5_q;
  meta_t          m5_q;
  logic [SQW-1:0] s2_5_q;
  logic [NAW-1:0] num_5_q;
  logic [NAW:0]   lhs, rhs;
  logic [NAW-1:0] diff;

  // Stage 6: saturation test and dividend
  logic           v6_q;
  meta_t          m6_q;
  logic [SQW-1:0] d6_q;
  logic [XW-1:0]  x6_q;
  meta_t          m6_d;

  always_comb begin
    n2_ext = QW'(n2_2_q);
    na_acc = '0;
    nb_acc = '0;
    for (int j = 0; j < 4; j++) begin
      na_acc = na_acc + ((QW + FACT_W)'(pa_q[j]) << (j * H));
      nb_acc = nb_acc + ((QW + FACT_W)'(pb_q[j]) << (j * H));
    end
    lhs  = (NAW + 1)'(na_4_q) + (NAW + 1)'(nb_4_q);
    rhs  = (NAW + 1)'({s2_4_q, 8'b0});
    diff = NAW'({s2_4_q, 8'b0}) - na_4_q;
    m6_d = m5_q;
    m6_d.sat = (num_5_q >= {s2_5_q, 16'b0});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_q  <= meta_in;
      sll_q <= PW'(s_lo) * PW'(s_lo);
      slh_q <= PW'(s_lo) * PW'(s_hi);
      shh_q <= PW'(s_hi) * PW'(s_hi);
      nll_q <= PW'(n_lo) * PW'(n_lo);
      nlh_q <= PW'(n_lo) * PW'(n_hi);
      nhh_q <= PW'(n_hi) * PW'(n_hi);
      a1_q  <= in_a;
      b1_q  <= in_b;

      m2_q   <= m1_q;
      s2_2_q <= SQW'((QW'(shh_q) << (2 * H)) + (QW'(slh_q) << (H + 1)) + QW'(sll_q));
      n2_2_q <= SQW'((QW'(nhh_q) << (2 * H)) + (QW'(nlh_q) << (H + 1)) + QW'(nll_q));
      a2_q   <= a1_q;
      b2_q   <= b1_q;

      m3_q   <= m2_q;
      s2_3_q <= s2_2_q;
      for (int j = 0; j < 4; j++) begin
        pa_q[j] <= CPW'(n2_ext[j*H +: H]) * CPW'(a2_q);
        pb_q[j] <= CPW'(n2_ext[j*H +: H]) * CPW'(b2_q);
      end

      m4_q   <= m3_q;
      s2_4_q <= s2_3_q;
      na_4_q <= NAW'(na_acc);
      nb_4_q <= NAW'(nb_acc);

      m5_q    <= m4_q;
      s2_5_q  <= s2_4_q;
      num_5_q <= (lhs < rhs) ? diff : nb_4_q;

      m6_q <= m6_d;
      d6_q <= s2_5_q;
      x6_q <= {num_5_q, 16'b0};
    end
  end

  logic              dv;
  meta_t             dm;
  logic [QUOT_W-1:0] dq;

  gssg_div #(
    .DW(SQW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (v6_q),
    .meta_i     (m6_q),
    .divisor_i  (d6_q),
    .dividend_i (x6_q),
    .valid_o    (dv),
    .meta_o     (dm),
    .quot_o     (dq)
  );

  logic              rv;
  meta_t             rm;
  logic [GAIN_W-1:0] root;

  gssg_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv),
    .meta_i  (dm),
    .rad_i   (dq),
    .valid_o (rv),
    .meta_o  (rm),
    .root_o  (root)
  );

  logic              ov_q, phase_q;
  logic [GAIN_W-1:0] gain_q;
  meta_t             om_q;
  logic              olast;

  assign olast = phase_q || !om_q.mirror;
  assign en    = !ov_q || (m_axis_tready && olast);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q    <= 1'b0;
      phase_q <= 1'b0;
    end else if (en) begin
      ov_q    <= rv;
      phase_q <= 1'b0;
    end else if (m_axis_tready) begin
      phase_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      om_q   <= rm;
      gain_q <= rm.unity ? UNITY_GAIN : (rm.sat ? SAT_GAIN : root);
    end
  end

  assign s_axis_tready = en;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tlast  = olast;
  assign m_axis_tdata  = {3'b0, (phase_q ? om_q.mirr_idx : om_q.idx), gain_q};

endmodule

[design/gssg_checker.sv]
// Port-level checks for the gain block and their binding.
module gssg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  a_reset_idle : assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("output valid during reset");

  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("stalled transfer changed");

  a_mirror_pair : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && m_axis_tlast
      && $stable(m_axis_tdata[15:0]))
    else $error("mirrored result does not follow with the same gain");

  a_mirror_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |-> m_axis_tdata[28:16] != 13'd0)
    else $error("bin zero marked for mirroring");

endmodule

bind generalized_spectral_subtraction_gain gssg_checker u_gssg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

[sim/tb.sv]
// Testbench for the spectral subtraction gain block: random and directed bins, scoreboard check.
module tb;
  import gssg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] beta;
    logic [15:0] alpha;
    logic [31:0] noise;
    logic [31:0] sig;
    logic [12:0] idx;
  } bin_t;

  typedef struct packed {
    logic [15:0] gain;
    logic [12:0] gidx;
    logic        last;
  } gain_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_wr_en_i = 1'b0;
  logic [IDX_W-1:0] cfg_wr_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic m_axis_tlast;

  bin_t bin_q[$];
  gain_res_t gain_q[$];
  int errors = 0;
  int src_idle = 0;
  int dst_idle = 0;
  logic [12:0] half_reg = 13'd512;

  generalized_spectral_subtraction_gain u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_wr_en_i(cfg_wr_en_i), .cfg_wr_data_i(cfg_wr_data_i),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [15:0] power_gain(bin_t b);
    logic [63:0] s2, n2, q, rem, res, bitv;
    logic [191:0] lhs, rhs, num, den;
    if (b.sig == 0) return UNITY_GAIN;
    s2 = 64'(b.sig) * 64'(b.sig);
    n2 = 64'(b.noise) * 64'(b.noise);
    lhs = 192'(n2) * (192'(b.alpha) + 192'(b.beta));
    rhs = 192'(s2) << 8;
    if (lhs < rhs) num = rhs - 192'(n2) * 192'(b.alpha);
    else num = 192'(n2) * 192'(b.beta);
    num = num << 16;
    den = 192'(s2);
    if (num >= (den << 32)) return SAT_GAIN;
    q = 64'(num / den);
    rem = q;
    res = 0;
    bitv = 64'd1 << 30;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[15:0];
  endfunction

  function automatic void predict_gains(bin_t b);
    logic [12:0] half;
    logic [15:0] g;
    logic mirror;
    half = (half_reg > 13'd4096) ? 13'd4096 : half_reg;
    g = power_gain(b);
    mirror = (b.idx > 0) && (b.idx < half);
    gain_q.push_back('{gain: g, gidx: b.idx, last: !mirror});
    if (mirror) gain_q.push_back('{gain: g, gidx: 13'(2 * half - b.idx), last: 1'b1});
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (bin_q.size() > 0 && $urandom_range(99) >= src_idle) begin
          bin_t b;
          b = bin_q.pop_front();
          predict_gains(b);
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {3'b0, b};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= dst_idle);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      gain_res_t got, want;
      got = '{gain: m_axis_tdata[15:0], gidx: m_axis_tdata[28:16], last: m_axis_tlast};
      if (gain_q.size() == 0) begin
        $display("%0t unexpected transfer: expected none actual %h", $time, got);
        errors++;
      end else begin
        want = gain_q.pop_front();
        if (got.gain !== want.gain)
          $display("%0t gain: expected %h actual %h", $time, want.gain, got.gain);
        if (got.gidx !== want.gidx)
          $display("%0t index: expected %0d actual %0d", $time, want.gidx, got.gidx);
        if (got.last !== want.last)
          $display("%0t last: expected %b actual %b", $time, want.last, got.last);
        if (got !== want) errors++;
      end
    end
  end

  function automatic bin_t rand_bin(logic [12:0] half);
    bin_t b;
    int k;
    b.idx = (half == 0 || $urandom_range(9) == 0) ? 13'($urandom) :
            13'($urandom_range(half > 4096 ? 4096 : half));
    k = $urandom_range(3);
    b.sig = (k == 0) ? $urandom : 32'($urandom) >> $urandom_range(31);
    if ($urandom_range(19) == 0) b.sig = 0;
    b.noise = (k == 1) ? $urandom : 32'($urandom) >> $urandom_range(31);
    if ($urandom_range(1)) b.noise = b.sig >> $urandom_range(4);
    b.alpha = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1536));
    b.beta = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(64));
    return b;
  endfunction

  task automatic drain();
    while (bin_q.size() > 0 || gain_q.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic set_half(logic [12:0] v);
    cfg_wr_en_i <= 1'b1;
    cfg_wr_data_i <= v;
    half_reg = v;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
  endtask

  initial begin
    logic [12:0] halves[6];
    bin_t b;
    halves = '{13'd512, 13'd1, 13'd0, 13'd8191, 13'd4096, 13'd37};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    bin_q.push_back('{beta: 16'd0, alpha: 16'd0, noise: 32'd5, sig: 32'd0, idx: 13'd0});
    bin_q.push_back('{beta: 16'hFFFF, alpha: 16'hFFFF, noise: 32'hFFFFFFFF,
                      sig: 32'hFFFFFFFF, idx: 13'd512});
    bin_q.push_back('{beta: 16'd0, alpha: 16'd0, noise: 32'hFFFFFFFF, sig: 32'd1, idx: 13'd1});
    bin_q.push_back('{beta: 16'd0, alpha: 16'd512, noise: 32'd100, sig: 32'd100, idx: 13'd511});
    bin_q.push_back('{beta: 16'hFFFF, alpha: 16'd256, noise: 32'hFFFFFFFF, sig: 32'd1,
                      idx: 13'd8191});
    bin_q.push_back('{beta: 16'd10, alpha: 16'd256, noise: 32'd0, sig: 32'd1, idx: 13'd600});
    bin_q.push_back('{beta: 16'd0, alpha: 16'd0, noise: 32'd0, sig: 32'hFFFFFFFF, idx: 13'd2});
    bin_q.push_back('{beta: 16'd16, alpha: 16'd256, noise: 32'd1000, sig: 32'd10,
                      idx: 13'd256});
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      set_half(halves[ph]);
      src_idle = (ph < 2) ? 16 : (ph < 4) ? 63 : 0;
      dst_idle = (ph < 2) ? 63 : (ph < 4) ? 16 : 0;
      for (int i = 0; i < 325; i++) bin_q.push_back(rand_bin(halves[ph]));
      drain();
    end
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end
endmodule
